// ===== sv/ssnt_pkg.sv =====
// Package for the seven-segment number/time writer: types, constants, helper functions.
package ssnt_pkg;

	// Defaults and fixed sizes
	localparam int DIGIT_COUNT_DEFAULT = 8;
	localparam int MAX_WRITES          = 8;
	localparam int BCD_DIGITS          = 9;
	localparam int BCD_W               = 4 * BCD_DIGITS;

	localparam logic [7:0] ADDR_BASE = 8'hC0;
	localparam logic [7:0] SEG_DASH  = 8'h40;
	localparam logic [7:0] SEG_BLANK = 8'h00;

	localparam logic [2:0] BRIGHTNESS_RESET = 3'd3;

	// Command codes
	localparam logic CMD_NUMBER = 1'b0;
	localparam logic CMD_TIME   = 1'b1;

	typedef logic [BCD_W-1:0] bcd_t;

	typedef struct packed {
		logic        command;
		logic [26:0] number_value;
		logic [6:0]  hours;
		logic [6:0]  minutes;
		logic [6:0]  seconds;
	} request_t;

	typedef struct packed {
		logic [7:0] ram_address;
		logic [7:0] segment_pattern;
		logic       last_write;
	} result_t;

	typedef struct packed {
		logic [3:0] h_tens;
		logic [3:0] h_ones;
		logic [3:0] m_tens;
		logic [3:0] m_ones;
		logic [3:0] s_tens;
		logic [3:0] s_ones;
	} time_digits_t;

	// Hex digit to segment code
	function automatic logic [7:0] seg_hex(logic [3:0] d);
		logic [7:0] p;
		case (d)
			4'h0: p = 8'h3F;
			4'h1: p = 8'h06;
			4'h2: p = 8'h5B;
			4'h3: p = 8'h4F;
			4'h4: p = 8'h66;
			4'h5: p = 8'h6D;
			4'h6: p = 8'h7D;
			4'h7: p = 8'h07;
			4'h8: p = 8'h7F;
			4'h9: p = 8'h6F;
			4'hA: p = 8'h77;
			4'hB: p = 8'h7C;
			4'hC: p = 8'h39;
			4'hD: p = 8'h5E;
			4'hE: p = 8'h79;
			default: p = 8'h71;
		endcase
		return p;
	endfunction

	// One double-dabble step: add 3 to digits of 5 or more, then shift a bit in
	function automatic bcd_t dd_step(bcd_t b, logic bit_in);
		bcd_t t;
		t = b;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (t[4*i +: 4] >= 4'd5) begin
				t[4*i +: 4] = t[4*i +: 4] + 4'd3;
			end
		end
		return {t[BCD_W-2:0], bit_in};
	endfunction

	// Tens and ones of a 7-bit value; x*205 >> 11 equals x/10 for x below 128
	function automatic logic [7:0] split10(logic [6:0] v);
		logic [14:0] p;
		logic [3:0]  q;
		logic [6:0]  r;
		p = 15'(v) * 15'd205;
		q = p[14:11];
		r = v - 7'(q) * 7'd10;
		return {q, r[3:0]};
	endfunction

endpackage

// ===== sv/seven_segment_number_time_writer_core.sv =====
// Top level of the seven-segment number/time writer: conversion pipeline and write sequencer.
// Each request produces display-RAM writes, one per cycle, on result with result_strobe high
// for exactly one cycle each; the receiver cannot stall them. A request is taken when start is
// high and busy is low. Number mode (command 0) writes min(DIGIT_COUNT, 8) positions right to
// left, the value right-aligned with leading positions blanked; time mode (command 1) writes
// HH-MM-SS to positions 0..7 left to right. last_write marks the final write of a request. The
// value passes a four-stage binary-to-BCD pipeline (seven, seven, seven and six shift steps),
// then a sequencer that issues one write per cycle, with no gap between the writes of queued
// requests; the first write is on the ports once the request has passed stages s1 to s4 and
// been loaded into the sequencer. Up to four further requests queue in the pipeline while
// writes go out; busy rises when it is full. brightness is held for the display command and
// does not alter the writes.
module seven_segment_number_time_writer_core #(
	parameter int DIGIT_COUNT = ssnt_pkg::DIGIT_COUNT_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ssnt_pkg::request_t request,
	output logic               result_strobe,
	output ssnt_pkg::result_t  result,
	input  logic               brightness_we,
	input  logic [2:0]         brightness_wdata
);
	import ssnt_pkg::*;

	localparam int         NUM_WRITES = (DIGIT_COUNT < MAX_WRITES) ? DIGIT_COUNT : MAX_WRITES;
	localparam logic [2:0] LAST_NUM   = 3'(NUM_WRITES - 1);
	localparam logic [2:0] LAST_TIME  = 3'(MAX_WRITES - 1);
	localparam logic [3:0] POS_TOP    = 4'(DIGIT_COUNT - 1);

	// Brightness register
	logic [2:0] brightness_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BRIGHTNESS_RESET;
		end else if (brightness_we) begin
			brightness_q <= brightness_wdata;
		end
	end

	// Pipeline registers
	logic         valid_s1, valid_s2, valid_s3, valid_s4;
	logic         cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	bcd_t         bcd_s1, bcd_s2, bcd_s3, bcd_s4;
	logic [19:0]  bin_s1;
	logic [12:0]  bin_s2;
	logic [5:0]   bin_s3;
	time_digits_t tim_s1, tim_s2, tim_s3, tim_s4;

	// Sequencer registers
	logic             active_q;
	logic             mode_q;
	logic [2:0]       idx_q;
	logic [7:0][7:0]  pat_q;

	logic seq_last, seq_free, go4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic accept;

	// Handshake chain: a stage takes new data when empty or when its content moves on
	assign seq_last = active_q && (idx_q == (mode_q == CMD_TIME ? LAST_TIME : LAST_NUM));
	assign seq_free = !active_q || seq_last;
	assign go4      = valid_s4 && seq_free;
	assign rdy4     = !valid_s4 || go4;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign busy     = !rdy1;
	assign accept   = start && rdy1;

	// Conversion steps for each stage, most significant bits first
	bcd_t         bcd_n1, bcd_n2, bcd_n3, bcd_n4;
	time_digits_t tim_n1;

	always_comb begin
		bcd_n1 = '0;
		for (int i = 0; i < 7; i++) begin
			bcd_n1 = dd_step(bcd_n1, request.number_value[26-i]);
		end
		bcd_n2 = bcd_s1;
		for (int i = 0; i < 7; i++) begin
			bcd_n2 = dd_step(bcd_n2, bin_s1[19-i]);
		end
		bcd_n3 = bcd_s2;
		for (int i = 0; i < 7; i++) begin
			bcd_n3 = dd_step(bcd_n3, bin_s2[12-i]);
		end
		bcd_n4 = bcd_s3;
		for (int i = 0; i < 6; i++) begin
			bcd_n4 = dd_step(bcd_n4, bin_s3[5-i]);
		end
	end

	// Time fields split into tens and ones at entry
	always_comb begin
		{tim_n1.h_tens, tim_n1.h_ones} = split10(request.hours);
		{tim_n1.m_tens, tim_n1.m_ones} = split10(request.minutes);
		{tim_n1.s_tens, tim_n1.s_ones} = split10(request.seconds);
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= accept;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (rdy1) begin
			cmd_s1 <= request.command;
			bcd_s1 <= bcd_n1;
			bin_s1 <= request.number_value[19:0];
			tim_s1 <= tim_n1;
		end
		if (rdy2) begin
			cmd_s2 <= cmd_s1;
			bcd_s2 <= bcd_n2;
			bin_s2 <= bin_s1[12:0];
			tim_s2 <= tim_s1;
		end
		if (rdy3) begin
			cmd_s3 <= cmd_s2;
			bcd_s3 <= bcd_n3;
			bin_s3 <= bin_s2[5:0];
			tim_s3 <= tim_s2;
		end
		if (rdy4) begin
			cmd_s4 <= cmd_s3;
			bcd_s4 <= bcd_n4;
			tim_s4 <= tim_s3;
		end
	end

	// Segment patterns in write order; digit k>0 blanks when it and all above are zero
	logic [7:0][7:0] pat_n;

	always_comb begin
		if (cmd_s4 == CMD_TIME) begin
			pat_n[0] = seg_hex(tim_s4.h_tens);
			pat_n[1] = seg_hex(tim_s4.h_ones);
			pat_n[2] = SEG_DASH;
			pat_n[3] = seg_hex(tim_s4.m_tens);
			pat_n[4] = seg_hex(tim_s4.m_ones);
			pat_n[5] = SEG_DASH;
			pat_n[6] = seg_hex(tim_s4.s_tens);
			pat_n[7] = seg_hex(tim_s4.s_ones);
		end else begin
			for (int k = 0; k < MAX_WRITES; k++) begin
				if (k != 0 && (bcd_s4 >> (4 * k)) == '0) begin
					pat_n[k] = SEG_BLANK;
				end else begin
					pat_n[k] = seg_hex(bcd_s4[4*k +: 4]);
				end
			end
		end
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (go4) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (seq_last) begin
			active_q <= 1'b0;
		end else if (active_q) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	// Sequencer patterns shift down one per write
	always_ff @(posedge clk) begin
		if (go4) begin
			mode_q <= cmd_s4;
			pat_q  <= pat_n;
		end else if (active_q) begin
			pat_q <= {SEG_BLANK, pat_q[7:1]};
		end
	end

	// Result drive
	logic [3:0] pos;

	assign pos                    = (mode_q == CMD_TIME) ? {1'b0, idx_q} : POS_TOP - {1'b0, idx_q};
	assign result_strobe          = active_q;
	assign result.ram_address     = ADDR_BASE + {3'b000, pos, 1'b0};
	assign result.segment_pattern = pat_q[0];
	assign result.last_write      = seq_last;

`ifndef SYNTH
	// No gap inside the writes of one request
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last_write |=> result_strobe)
		else $error("write sequence broken before last write");

	// Last write only ever marks a live write
	a_last_strobed: assert property (@(posedge clk) disable iff (!arst_n)
		result.last_write |-> result_strobe)
		else $error("last_write without strobe");

	// An accepted request lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> valid_s1)
		else $error("accepted request lost at entry");

	// A request leaving the pipeline starts a write on the next cycle
	a_hand_off: assert property (@(posedge clk) disable iff (!arst_n)
		go4 |=> result_strobe && idx_q == 3'd0)
		else $error("hand-off did not start a write sequence");

	// Brightness changes only on a write
	a_bright_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!brightness_we |=> $stable(brightness_q))
		else $error("brightness changed without write");
`endif

endmodule
